>>> rtl/gopd_pkg.sv
`default_nettype none

package gopd_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int MAX_CONTOURS_DEF = 16;

  // last header byte index: contour count (2 bytes) plus bounding box (8 bytes)
  localparam logic [3:0] HDR_LAST = 4'd9;

  // flag byte bit positions
  localparam int FLAG_ON_CURVE = 0;
  localparam int FLAG_X_SHORT  = 1;
  localparam int FLAG_Y_SHORT  = 2;
  localparam int FLAG_REPEAT   = 3;
  localparam int FLAG_X_SAME   = 4;
  localparam int FLAG_Y_SAME   = 5;

  localparam logic [1:0] STATUS_POINT    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_ENDS,
    PH_INSLEN,
    PH_INSSKIP,
    PH_FLAGS,
    PH_REPEAT,
    PH_FILL,
    PH_PASS_X,
    PH_PASS_Y
  } phase_t;

endpackage

`default_nettype wire

>>> rtl/gopd_byte_if.sv
`default_nettype none

interface gopd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/gopd_point_if.sv
`default_nettype none

interface gopd_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] y_coord;
  logic               on_curve;
  logic               contour_end;
  logic [1:0]         status;
  logic               last_result;

  modport source (output valid, output x_coord, output y_coord, output on_curve,
                  output contour_end, output status, output last_result, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input on_curve,
                  input contour_end, input status, input last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/glyph_outline_point_decoder.sv
// Simple glyph outline decoder.
// byte_in (sink) takes the bytes of one simple glyph record in file order:
// contour count, bounding box, contour end indices, instruction length and
// bytes, flags with repeat runs, X deltas, Y deltas. point_out (source) gives
// one item per point during the Y pass, with absolute wrapped coordinates,
// on-curve and contour-end marks; last_result marks the final item of a glyph.
// A contour count of zero or less gives one item with status empty; too many
// contours, too many points or a repeat run past the point count gives one
// item with status overflow. After the last item the next header is expected.
// Throughput: one byte per cycle while point_out does not stall, but the input
// is held while a repeat run writes its flags into the point memory, and a point
// whose delta needs no byte takes no byte. Both follow from the single write port
// of the point memory and one point visited per cycle. Each item is registered
// and shows in the cycle after the byte that completes it (or after its
// zero-byte point cycle).
// Reset (rst, synchronous) returns to the header phase and drops any pending
// item; no clearing pass is needed. While point_out stalls with an item held,
// only instruction length, instruction and X pass bytes keep flowing; all
// other bytes and zero-byte Y points wait for the output register.
`default_nettype none

module glyph_outline_point_decoder
  import gopd_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_CONTOURS = MAX_CONTOURS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  gopd_byte_if.sink     byte_in,
  gopd_point_if.source  point_out
);

  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CIDX_W  = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam int CCNT_W  = $clog2(MAX_CONTOURS + 1);
  localparam int RSUM_W  = ((PCNT_W > 8) ? PCNT_W : 8) + 1;
  localparam int PENT_W  = 24;

  // control and state registers
  phase_t              phase, phase_next;
  logic [3:0]          fcnt, fcnt_next;
  logic [7:0]          hold, hold_next;
  logic [CCNT_W-1:0]   ctotal, ctotal_next;
  logic [15:0]         iskip, iskip_next;
  logic [PCNT_W-1:0]   ptotal, ptotal_next;
  logic [PCNT_W-1:0]   pi, pi_next;
  logic [CCNT_W-1:0]   ci, ci_next;
  logic [15:0]         running, running_next;
  logic [7:0]          rep_flag, rep_flag_next;
  logic [PCNT_W-1:0]   rep_left, rep_left_next;

  // output register
  logic                o_valid;
  logic [15:0]         o_x, o_y;
  logic                o_on, o_ce, o_last;
  logic [1:0]          o_status;

  // memories
  logic                pt_we;
  logic [PIDX_W-1:0]   pt_waddr, pt_raddr;
  logic [PENT_W-1:0]   pt_wdata, pt_rd;
  logic                ends_we;
  logic [CIDX_W-1:0]   ends_waddr, ends_raddr;
  logic [15:0]         ends_wdata, ends_rd;

  // decode
  logic [7:0]          b;
  logic [15:0]         word;
  logic                out_free;
  logic [7:0]          flag;
  logic [15:0]         xval;
  logic                is_x, in_pass;
  logic                short_d, same_d, need0, need2;
  logic                in_rdy, acc, drain, finish;
  logic [15:0]         coord_new;
  logic [PCNT_W-1:0]   pi_inc;
  logic                pi_last;
  logic [CCNT_W-1:0]   ci_inc;
  logic                ci_last;
  logic                y_ce;
  logic [RSUM_W-1:0]   rsum;
  logic                hdr_empty, hdr_ovf, ends_ovf, ends_wr, flags_ovf, rep_ovf;
  logic                y_emit, emit;
  logic                e_ovf;

  assign b    = byte_in.data_byte;
  assign word = {hold, b};

  gopd_ram #(.DEPTH(MAX_POINTS), .WIDTH(PENT_W)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rd)
  );

  gopd_ram #(.DEPTH(MAX_CONTOURS), .WIDTH(16)) u_ends_ram (
    .clk   (clk),
    .we    (ends_we),
    .waddr (ends_waddr),
    .wdata (ends_wdata),
    .raddr (ends_raddr),
    .rdata (ends_rd)
  );

  // read addresses follow the next index, so the entry of the current point is
  // always in the read register
  assign pt_raddr   = (pi_next < PCNT_W'(MAX_POINTS)) ? pi_next[PIDX_W-1:0] : '0;
  assign ends_raddr = (ci_next < CCNT_W'(MAX_CONTOURS)) ? ci_next[CIDX_W-1:0] : '0;

  always_comb begin : decode
    out_free = !o_valid || point_out.ready;
    flag     = pt_rd[23:16];
    xval     = pt_rd[15:0];
    is_x     = (phase == PH_PASS_X);
    in_pass  = (phase == PH_PASS_X) || (phase == PH_PASS_Y);
    short_d  = is_x ? flag[FLAG_X_SHORT] : flag[FLAG_Y_SHORT];
    same_d   = is_x ? flag[FLAG_X_SAME]  : flag[FLAG_Y_SAME];
    need0    = !short_d && same_d;
    need2    = !short_d && !same_d;

    case (phase)
      PH_FILL:                in_rdy = 1'b0;
      PH_PASS_X:              in_rdy = !need0;
      PH_PASS_Y:              in_rdy = !need0 && out_free;
      PH_INSLEN, PH_INSSKIP:  in_rdy = 1'b1;
      default:                in_rdy = out_free;
    endcase

    acc    = byte_in.valid && in_rdy;
    drain  = in_pass && need0 && (is_x || out_free);
    finish = drain || (acc && in_pass && (short_d || (need2 && fcnt == 4'd1)));

    if (need0) begin
      coord_new = running;
    end else if (short_d) begin
      coord_new = same_d ? (running + {8'h00, b}) : (running - {8'h00, b});
    end else begin
      coord_new = running + word;
    end

    pi_inc  = pi + PCNT_W'(1);
    pi_last = ({1'b0, pi} + (PCNT_W+1)'(1)) >= {1'b0, ptotal};
    ci_inc  = ci + CCNT_W'(1);
    ci_last = ({1'b0, ci} + (CCNT_W+1)'(1)) >= {1'b0, ctotal};
    y_ce    = (ci < ctotal) && (ci < CCNT_W'(MAX_CONTOURS)) && (16'(pi) == ends_rd);
    rsum    = RSUM_W'(pi) + RSUM_W'(b);

    hdr_empty = (phase == PH_HEADER) && acc && (fcnt == 4'd1) &&
                ((word == 16'h0000) || word[15]);
    hdr_ovf   = (phase == PH_HEADER) && acc && (fcnt == 4'd1) && !hdr_empty &&
                (word > 16'(MAX_CONTOURS));
    ends_wr   = (phase == PH_ENDS) && acc && (fcnt == 4'd1) &&
                (ci < CCNT_W'(MAX_CONTOURS));
    ends_ovf  = ((phase == PH_ENDS) && acc && (fcnt == 4'd1) && !ends_wr) ||
                (ends_wr && ci_last && (word >= 16'(MAX_POINTS)));
    flags_ovf = (phase == PH_FLAGS) && acc &&
                ((pi >= PCNT_W'(MAX_POINTS)) || (pi >= ptotal));
    rep_ovf   = (phase == PH_REPEAT) && acc &&
                ((pi == '0) || (rsum > RSUM_W'(ptotal)) || (rsum > RSUM_W'(MAX_POINTS)));
    y_emit    = (phase == PH_PASS_Y) && finish;
    e_ovf     = hdr_ovf || ends_ovf || flags_ovf || rep_ovf;
    emit      = y_emit || hdr_empty || e_ovf;
  end

  always_comb begin : next_state
    phase_next    = phase;
    fcnt_next     = fcnt;
    hold_next     = hold;
    ctotal_next   = ctotal;
    iskip_next    = iskip;
    ptotal_next   = ptotal;
    pi_next       = pi;
    ci_next       = ci;
    running_next  = running;
    rep_flag_next = rep_flag;
    rep_left_next = rep_left;

    case (phase)
      PH_HEADER: begin
        if (acc) begin
          if (fcnt == 4'd0) begin
            hold_next = b;
            fcnt_next = 4'd1;
          end else if (fcnt == 4'd1) begin
            if (hdr_empty || hdr_ovf) begin
              fcnt_next = 4'd0;
            end else begin
              ctotal_next = word[CCNT_W-1:0];
              fcnt_next   = 4'd2;
            end
          end else if (fcnt < HDR_LAST) begin
            fcnt_next = fcnt + 4'd1;
          end else begin
            phase_next = PH_ENDS;
            fcnt_next  = 4'd0;
            ci_next    = '0;
          end
        end
      end
      PH_ENDS: begin
        if (acc) begin
          if (fcnt == 4'd0) begin
            hold_next = b;
            fcnt_next = 4'd1;
          end else begin
            fcnt_next = 4'd0;
            if (ends_ovf) begin
              phase_next = PH_HEADER;
            end
            if (ends_wr) begin
              ci_next = ci_inc;
              if (ci_last && !ends_ovf) begin
                ptotal_next = word[PCNT_W-1:0] + PCNT_W'(1);
                phase_next  = PH_INSLEN;
              end
            end
          end
        end
      end
      PH_INSLEN: begin
        if (acc) begin
          if (fcnt == 4'd0) begin
            hold_next = b;
            fcnt_next = 4'd1;
          end else begin
            fcnt_next  = 4'd0;
            iskip_next = word;
            pi_next    = '0;
            phase_next = (word == 16'h0000) ? PH_FLAGS : PH_INSSKIP;
          end
        end
      end
      PH_INSSKIP: begin
        if (acc) begin
          iskip_next = iskip - 16'd1;
          if (iskip == 16'd1) begin
            pi_next    = '0;
            phase_next = PH_FLAGS;
          end
        end
      end
      PH_FLAGS: begin
        if (acc) begin
          if (flags_ovf) begin
            phase_next = PH_HEADER;
            fcnt_next  = 4'd0;
          end else begin
            pi_next = pi_inc;
            if (b[FLAG_REPEAT]) begin
              rep_flag_next = b;
              phase_next    = PH_REPEAT;
            end else if (pi_last) begin
              phase_next   = PH_PASS_X;
              pi_next      = '0;
              ci_next      = '0;
              running_next = '0;
              fcnt_next    = 4'd0;
            end
          end
        end
      end
      PH_REPEAT: begin
        if (acc) begin
          if (rep_ovf) begin
            phase_next = PH_HEADER;
            fcnt_next  = 4'd0;
          end else if (b == 8'h00) begin
            if (pi >= ptotal) begin
              phase_next   = PH_PASS_X;
              pi_next      = '0;
              ci_next      = '0;
              running_next = '0;
              fcnt_next    = 4'd0;
            end else begin
              phase_next = PH_FLAGS;
            end
          end else begin
            rep_left_next = b[PCNT_W-1:0];
            phase_next    = PH_FILL;
          end
        end
      end
      PH_FILL: begin
        pi_next       = pi_inc;
        rep_left_next = rep_left - PCNT_W'(1);
        if (rep_left == PCNT_W'(1)) begin
          if (pi_last) begin
            phase_next   = PH_PASS_X;
            pi_next      = '0;
            ci_next      = '0;
            running_next = '0;
            fcnt_next    = 4'd0;
          end else begin
            phase_next = PH_FLAGS;
          end
        end
      end
      PH_PASS_X, PH_PASS_Y: begin
        if (acc && need2 && (fcnt == 4'd0)) begin
          hold_next = b;
          fcnt_next = 4'd1;
        end
        if (finish) begin
          fcnt_next    = 4'd0;
          running_next = coord_new;
          if (is_x) begin
            if (pi_last) begin
              phase_next   = PH_PASS_Y;
              pi_next      = '0;
              ci_next      = '0;
              running_next = '0;
            end else begin
              pi_next = pi_inc;
            end
          end else begin
            if (y_ce) begin
              ci_next = ci_inc;
            end
            if (pi_last) begin
              phase_next = PH_HEADER;
            end else begin
              pi_next = pi_inc;
            end
          end
        end
      end
      default: begin
        phase_next = PH_HEADER;
        fcnt_next  = 4'd0;
      end
    endcase
  end

  always_comb begin : outputs
    byte_in.ready = in_rdy;

    // flags go in with a zero x; the X pass rewrites the entry keeping its flag
    pt_we    = 1'b0;
    pt_waddr = pi[PIDX_W-1:0];
    pt_wdata = {flag, coord_new};
    case (phase)
      PH_FLAGS: begin
        pt_we    = acc && !flags_ovf;
        pt_wdata = {b, 16'h0000};
      end
      PH_FILL: begin
        pt_we    = 1'b1;
        pt_wdata = {rep_flag, 16'h0000};
      end
      PH_PASS_X: begin
        pt_we = finish;
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase

    ends_we    = ends_wr;
    ends_waddr = ci[CIDX_W-1:0];
    ends_wdata = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      fcnt     <= 4'd0;
      hold     <= 8'h00;
      ctotal   <= '0;
      iskip    <= 16'h0000;
      ptotal   <= '0;
      pi       <= '0;
      ci       <= '0;
      running  <= 16'h0000;
      rep_flag <= 8'h00;
      rep_left <= '0;
      o_valid  <= 1'b0;
    end else begin
      phase    <= phase_next;
      fcnt     <= fcnt_next;
      hold     <= hold_next;
      ctotal   <= ctotal_next;
      iskip    <= iskip_next;
      ptotal   <= ptotal_next;
      pi       <= pi_next;
      ci       <= ci_next;
      running  <= running_next;
      rep_flag <= rep_flag_next;
      rep_left <= rep_left_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (point_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (y_emit) begin
        o_x      <= xval;
        o_y      <= coord_new;
        o_on     <= flag[FLAG_ON_CURVE];
        o_ce     <= y_ce;
        o_status <= STATUS_POINT;
        o_last   <= pi_last;
      end else begin
        o_x      <= 16'h0000;
        o_y      <= 16'h0000;
        o_on     <= 1'b0;
        o_ce     <= 1'b0;
        o_status <= e_ovf ? STATUS_OVERFLOW : STATUS_EMPTY;
        o_last   <= 1'b1;
      end
    end
  end

  assign point_out.valid       = o_valid;
  assign point_out.x_coord     = o_x;
  assign point_out.y_coord     = o_y;
  assign point_out.on_curve    = o_on;
  assign point_out.contour_end = o_ce;
  assign point_out.status      = o_status;
  assign point_out.last_result = o_last;

`ifndef SYNTH
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!o_valid || point_out.ready))
    else $error("item produced while output register still full");

  a_point_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FLAGS || phase == PH_FILL || phase == PH_PASS_X || phase == PH_PASS_Y)
    |-> (pi < ptotal))
    else $error("point index beyond point count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILL) |->
    ((rep_left != '0) && (({1'b0, pi} + {1'b0, rep_left}) <= {1'b0, ptotal})))
    else $error("repeat fill runs past point count");

  a_contour_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PASS_Y) |-> (ci <= ctotal))
    else $error("contour index beyond contour count");
`endif

endmodule

`default_nettype wire

>>> rtl/gopd_ram.sv
`default_nettype none

module gopd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-to-read bypass so a same-cycle write is seen on the next read
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
